// ===== src/sdfe_pkg.sv =====
// Shared types, constants and field tables of the status datagram field extractor.
package sdfe_pkg;

  // Message constants
  localparam logic [31:0] MagicWord  = 32'hADBCCBDA;
  localparam logic [31:0] NullLength = 32'hFFFFFFFF;
  localparam logic [31:0] StatusType = 32'd1;

  // Parser step codes (plain state vector)
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepMagic  = 5'd0;
  localparam logic [StepW-1:0] StepType   = 5'd2;
  localparam logic [StepW-1:0] StepFreq   = 5'd5;
  localparam logic [StepW-1:0] StepDone   = 5'd22;
  localparam logic [StepW-1:0] StepFail   = 5'd23;

  // Field kinds
  localparam logic [1:0] KindFix  = 2'd0;
  localparam logic [1:0] KindLen  = 2'd1;
  localparam logic [1:0] KindBody = 2'd2;

  // Capture tags; TagNone marks a string that is walked but not emitted
  localparam logic [2:0] TagDxCall = 3'd0;
  localparam logic [2:0] TagDeCall = 3'd1;
  localparam logic [2:0] TagDeGrid = 3'd2;
  localparam logic [2:0] TagDxGrid = 3'd3;
  localparam logic [2:0] TagNone   = 3'd4;

  // Verdict codes
  localparam logic [2:0] VerdictOk        = 3'd0;
  localparam logic [2:0] VerdictBadMagic  = 3'd1;
  localparam logic [2:0] VerdictOtherType = 3'd2;
  localparam logic [2:0] VerdictZeroFreq  = 3'd3;
  localparam logic [2:0] VerdictTrunc     = 3'd4;

  // Result kinds
  localparam logic KindChar    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Result queue depth
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  field_tag;
    logic [7:0]  text_byte;
    logic        last_of_text;
    logic [31:0] frequency_hz;
    logic [2:0]  verdict;
    logic        last_result;
  } result_t;

  // Up to two results pushed for one accepted byte, in output order
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } push_t;

  function automatic logic [1:0] step_kind_f(input logic [StepW-1:0] step);
    logic [1:0] k;
    unique case (step)
      5'd0, 5'd1, 5'd2, 5'd5, 5'd14, 5'd15:                     k = KindFix;
      5'd3, 5'd6, 5'd8, 5'd10, 5'd12, 5'd16, 5'd18, 5'd20:      k = KindLen;
      default:                                                  k = KindBody;
    endcase
    return k;
  endfunction

  // Byte count of a fixed-size field (length words are four bytes)
  function automatic logic [3:0] step_count_f(input logic [StepW-1:0] step);
    logic [3:0] c;
    unique case (step)
      5'd5, 5'd15: c = 4'd8;
      5'd14:       c = 4'd3;
      default:     c = 4'd4;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] step_tag_f(input logic [StepW-1:0] step);
    logic [2:0] t;
    unique case (step)
      5'd9:    t = TagDxCall;
      5'd17:   t = TagDeCall;
      5'd19:   t = TagDeGrid;
      5'd21:   t = TagDxGrid;
      default: t = TagNone;
    endcase
    return t;
  endfunction

endpackage

// ===== src/sdfe_intf.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
interface sdfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface sdfe_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  field_tag;
  logic [7:0]  text_byte;
  logic        last_of_text;
  logic [31:0] frequency_hz;
  logic [2:0]  verdict;
  logic        last_result;

  modport source (output valid, output result_kind, output field_tag, output text_byte,
                  output last_of_text, output frequency_hz, output verdict,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input field_tag, input text_byte,
                  input last_of_text, input frequency_hz, input verdict,
                  input last_result, output ready);
endinterface

// ===== src/sdfe_parser.sv =====
// Message walker: parse state registers and per-byte result generation.
module sdfe_parser
  import sdfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] packet_byte_i,
  input  logic       end_of_packet_i,
  output push_t      push_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [2:0]       idx_q, idx_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      freq_q, freq_d;
  logic [2:0]       verd_q, verd_d;

  logic [1:0]  kind;
  logic [2:0]  tag;
  logic [31:0] word;
  logic        char_v;
  result_t     char_r;
  result_t     verd_r;

  // Walk one byte, then close the packet on its last byte
  always_comb begin
    step_d = step_q;
    idx_d  = idx_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    freq_d = freq_q;
    verd_d = verd_q;
    kind   = step_kind_f(step_q);
    tag    = step_tag_f(step_q);
    word   = {acc_q[23:0], packet_byte_i};
    char_v = 1'b0;
    char_r = '0;
    verd_r = '0;

    if (fire_i && (step_q < StepDone)) begin
      if (kind == KindBody) begin
        if (tag != TagNone) begin
          char_v              = 1'b1;
          char_r.result_kind  = KindChar;
          char_r.field_tag    = tag[1:0];
          char_r.text_byte    = packet_byte_i;
          char_r.last_of_text = (rem_q == 32'd1);
        end
        rem_d = rem_q - 32'd1;
        if (rem_d == 32'd0) begin
          step_d = step_q + 5'd1;
        end
      end else begin
        acc_d = word;
        if (({1'b0, idx_q} + 4'd1) >= step_count_f(step_q)) begin
          idx_d = 3'd0;
          if (kind == KindLen) begin
            // all-ones length is a null string, same as empty
            if ((word == NullLength) || (word == 32'd0)) begin
              step_d = step_q + 5'd2;
            end else begin
              rem_d  = word;
              step_d = step_q + 5'd1;
            end
          end else if ((step_q == StepMagic) && (word != MagicWord)) begin
            step_d = StepFail;
            verd_d = VerdictBadMagic;
          end else if ((step_q == StepType) && (word != StatusType)) begin
            step_d = StepFail;
            verd_d = VerdictOtherType;
          end else begin
            if (step_q == StepFreq) begin
              freq_d = word;
            end
            step_d = step_q + 5'd1;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
    end

    if (fire_i && end_of_packet_i) begin
      verd_r.result_kind  = KindVerdict;
      verd_r.frequency_hz = freq_d;
      verd_r.last_result  = 1'b1;
      priority if (step_d == StepFail) begin
        verd_r.verdict = verd_d;
      end else if (step_d != StepDone) begin
        verd_r.verdict = VerdictTrunc;
      end else if (freq_d == 32'd0) begin
        verd_r.verdict = VerdictZeroFreq;
      end else begin
        verd_r.verdict = VerdictOk;
      end
      step_d = '0;
      idx_d  = '0;
      rem_d  = '0;
      acc_d  = '0;
      freq_d = '0;
      verd_d = '0;
    end
  end

  // Pack the results in output order
  always_comb begin
    push_o = '0;
    if (char_v) begin
      push_o.res_a             = char_r;
      push_o.res_a.last_result = !(fire_i && end_of_packet_i);
      push_o.res_b             = verd_r;
      push_o.count             = (fire_i && end_of_packet_i) ? 2'd2 : 2'd1;
    end else if (fire_i && end_of_packet_i) begin
      push_o.res_a = verd_r;
      push_o.count = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      idx_q  <= '0;
      rem_q  <= '0;
      acc_q  <= '0;
      freq_q <= '0;
      verd_q <= '0;
    end else begin
      step_q <= step_d;
      idx_q  <= idx_d;
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      freq_q <= freq_d;
      verd_q <= verd_d;
    end
  end

endmodule

// ===== src/sdfe_result_fifo.sv =====
// Small result queue: takes up to two results per cycle, gives one.
module sdfe_result_fifo
  import sdfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t head_o
);

  result_t       mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_nxt;

  assign valid_o    = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign pop        = valid_o && ready_i;
  // room for a character and a verdict from the next byte
  assign room_o     = (cnt_q <= (PtrW+1)'(FifoDepth - 2));
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + (PtrW+1)'(push_i.count) - (PtrW+1)'(pop);
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== src/status_datagram_field_extractor.sv =====
// Top level of the status datagram field extractor.
//
// Input channel in_i takes one datagram byte per request, with end_of_packet
// set on the final byte. The block walks the big-endian status message and
// sends on out_o one request for each character of the DX call, DE call,
// DE grid and DX grid strings, and one verdict request at the end of every
// packet; last_result marks the last request caused by an input byte.
// Each result is registered in the result queue before it appears on out_o.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_o.ready is high; a final byte that also emits a character gives
// two results, which leave the four-entry result queue one per cycle.
// in_i.ready is high while the queue has room for two results, so a stalled
// receiver stops input once three are queued; nothing is lost or repeated.
// Reset clears the parser to expect a magic word and empties the queue.
module status_datagram_field_extractor
  import sdfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sdfe_in_if.sink    in_i,
  sdfe_out_if.source out_o
);

  logic    fire;
  logic    room;
  push_t   push;
  result_t head;

  assign in_i.ready = room;
  assign fire       = in_i.valid && room;

  sdfe_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .packet_byte_i   (in_i.packet_byte),
    .end_of_packet_i (in_i.end_of_packet),
    .push_o          (push)
  );

  sdfe_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  // Result fields onto the output channel
  assign out_o.result_kind  = head.result_kind;
  assign out_o.field_tag    = head.field_tag;
  assign out_o.text_byte    = head.text_byte;
  assign out_o.last_of_text = head.last_of_text;
  assign out_o.frequency_hz = head.frequency_hz;
  assign out_o.verdict      = head.verdict;
  assign out_o.last_result  = head.last_result;

endmodule
